/* rtl/pts_pkg.sv */
// Shared types, codes and sizes of the periodic timer slot table.
package pts_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int TIME_W = 48;
	localparam int IVL_W = 31;

	localparam logic [1:0] OP_REGISTER = 2'd0;
	localparam logic [1:0] OP_UNREGISTER = 2'd1;
	localparam logic [1:0] OP_WORK = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [2:0] KIND_REGISTERED = 3'd0;
	localparam logic [2:0] KIND_FULL = 3'd1;
	localparam logic [2:0] KIND_UNREGISTERED = 3'd2;
	localparam logic [2:0] KIND_EMPTY = 3'd3;
	localparam logic [2:0] KIND_EXPIRED = 3'd4;
	localparam logic [2:0] KIND_DONE = 3'd5;
	localparam logic [2:0] KIND_CLEARED = 3'd6;

	typedef struct packed {
		logic [1:0] op;
		logic [TIME_W-1:0] now_us;
		logic [IVL_W-1:0] interval_len;
		logic one_shot;
		logic [3:0] slot_sel;
	} pts_in_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] slot_id;
		logic [4:0] fired_count;
		logic last;
	} pts_out_t;

	// Write request from the sequencer to the slot store.
	typedef struct packed {
		logic alloc;
		logic mark;
		logic advance;
		logic clear_all;
		logic sweep;
		logic [IDX_W-1:0] idx;
		logic once;
		logic [IVL_W-1:0] period;
		logic [TIME_W-1:0] deadline;
	} pts_cmd_t;

	// Contents of the slot picked by the read index.
	typedef struct packed {
		logic once;
		logic [IVL_W-1:0] period;
		logic [TIME_W-1:0] deadline;
	} pts_rd_t;

	typedef struct packed {
		logic [TIME_W-1:0] sum;
		logic le;
	} pts_alu_res_t;

endpackage

/* rtl/pts_alu.sv */
// Shared time adder and deadline comparator.
module pts_alu import pts_pkg::*; (
	input logic [TIME_W-1:0] add_a,
	input logic [IVL_W-1:0] add_b,
	input logic [TIME_W-1:0] cmp_x,
	input logic [TIME_W-1:0] cmp_y,
	output pts_alu_res_t res
);

	// Sum wraps modulo 2^48.
	assign res.sum = add_a + TIME_W'(add_b);
	assign res.le = (cmp_x <= cmp_y);

endmodule

/* rtl/pts_store.sv */
// Slot state: live and pending flags, per-slot timer fields, free-slot search.
module pts_store import pts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input pts_cmd_t cmd,
	input logic [IDX_W-1:0] rd_idx,
	output pts_rd_t rd,
	output logic [SLOTS-1:0] live,
	output logic [SLOTS-1:0] pending,
	output logic free_found,
	output logic [IDX_W-1:0] free_idx
);

	logic [SLOTS-1:0] live_q;
	logic [SLOTS-1:0] pend_q;
	logic once_q [SLOTS];
	logic [IVL_W-1:0] period_q [SLOTS];
	logic [TIME_W-1:0] deadline_q [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			pend_q <= '0;
		end else if (cmd.clear_all) begin
			live_q <= '0;
			pend_q <= '0;
		end else if (cmd.sweep) begin
			live_q <= live_q & ~pend_q;
			pend_q <= '0;
		end else if (cmd.alloc) begin
			live_q[cmd.idx] <= 1'b1;
			pend_q[cmd.idx] <= 1'b0;
		end else if (cmd.mark) begin
			pend_q[cmd.idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc) begin
			once_q[cmd.idx] <= cmd.once;
			period_q[cmd.idx] <= cmd.period;
			deadline_q[cmd.idx] <= cmd.deadline;
		end else if (cmd.advance) begin
			deadline_q[cmd.idx] <= cmd.deadline;
		end
	end

	assign rd.once = once_q[rd_idx];
	assign rd.period = period_q[rd_idx];
	assign rd.deadline = deadline_q[rd_idx];
	assign live = live_q;
	assign pending = pend_q;

	// Lowest slot that is not live.
	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!live_q[i]) begin
				free_found = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

endmodule

/* rtl/periodic_timer_slot_table_unit.sv */
// Top level of the periodic timer slot table: sequencer, result register, checks.
//
// The block keeps SLOTS timer slots and takes one item at a time. A register,
// unregister or clear item passes from acceptance to its execute state, which
// waits while its result cannot enter the result register (out_ready), and
// gives one result.
// A work item walks the slots one per cycle through a single shared 48-bit
// adder and comparator, pausing on a slot whose expired result waits for
// out_ready; it gives one expired result per live slot whose deadline is at
// or before now_us and closes with a work-done result that carries the
// count. The result register lets the last result of an item wait at the
// output while the next item is accepted. Slots marked by unregister or by
// a one-shot expiry still take part in the scan and are freed when the pass
// closes. Time arithmetic wraps modulo 2^48.
module periodic_timer_slot_table_unit import pts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input pts_in_t in_item,
	output logic out_valid,
	input logic out_ready,
	output pts_out_t out_item
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_FIN = 2'd3;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	logic [1:0] state_q;
	logic [1:0] state_d;
	pts_in_t in_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	pts_out_t out_q;
	logic out_valid_q;

	pts_cmd_t cmd;
	pts_rd_t rd;
	pts_alu_res_t alu;
	logic [SLOTS-1:0] live;
	logic [SLOTS-1:0] pending;
	logic free_found;
	logic [IDX_W-1:0] free_idx;
	logic [IDX_W-1:0] sel_idx;
	logic [IDX_W-1:0] rd_idx;
	logic sel_ok;
	logic can_push;
	logic push;
	pts_out_t push_item;
	logic hit;
	logic step;
	logic accept;
	logic [TIME_W-1:0] add_a;
	logic [IVL_W-1:0] add_b;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign can_push = !out_valid_q || out_ready;
	assign sel_idx = IDX_W'(in_q.slot_sel);
	assign sel_ok = (32'(in_q.slot_sel) < 32'(SLOTS));
	assign rd_idx = (state_q == ST_SCAN) ? idx_q : free_idx;

	// Share the adder: advance a deadline while scanning, else now + interval.
	assign add_a = (state_q == ST_SCAN) ? rd.deadline : in_q.now_us;
	assign add_b = (state_q == ST_SCAN) ? rd.period : in_q.interval_len;

	pts_alu u_alu (
		.add_a(add_a),
		.add_b(add_b),
		.cmp_x(rd.deadline),
		.cmp_y(in_q.now_us),
		.res(alu)
	);

	pts_store u_store (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.rd_idx(rd_idx),
		.rd(rd),
		.live(live),
		.pending(pending),
		.free_found(free_found),
		.free_idx(free_idx)
	);

	// A slot expires when it is live and its deadline is not after now.
	assign hit = live[idx_q] && alu.le;
	// Move on when nothing is to be emitted or the result register has room.
	assign step = !hit || can_push;

	always_comb begin
		state_d = state_q;
		push = 1'b0;
		push_item = '0;
		cmd = '0;
		cmd.idx = free_idx;
		cmd.once = in_q.one_shot;
		cmd.period = in_q.interval_len;
		cmd.deadline = alu.sum;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (in_item.op == OP_WORK) ? ST_SCAN : ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (can_push) begin
					push = 1'b1;
					push_item.last = 1'b1;
					state_d = ST_IDLE;
					case (in_q.op)
						OP_REGISTER: begin
							if (free_found) begin
								cmd.alloc = 1'b1;
								push_item.kind = KIND_REGISTERED;
								push_item.slot_id = 4'(free_idx);
							end else begin
								push_item.kind = KIND_FULL;
							end
						end
						OP_UNREGISTER: begin
							push_item.slot_id = in_q.slot_sel;
							cmd.idx = sel_idx;
							if (sel_ok && live[sel_idx]) begin
								cmd.mark = 1'b1;
								push_item.kind = KIND_UNREGISTERED;
							end else begin
								push_item.kind = KIND_EMPTY;
							end
						end
						OP_CLEAR: begin
							cmd.clear_all = 1'b1;
							push_item.kind = KIND_CLEARED;
						end
						default: begin
							push_item.kind = KIND_DONE;
						end
					endcase
				end
			end
			ST_SCAN: begin
				cmd.idx = idx_q;
				if (step) begin
					if (hit) begin
						push = 1'b1;
						push_item.kind = KIND_EXPIRED;
						push_item.slot_id = 4'(idx_q);
						// One-shot: mark for freeing; periodic: advance one period.
						cmd.mark = rd.once;
						cmd.advance = !rd.once;
					end
					if (idx_q == LAST_IDX) begin
						state_d = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				if (can_push) begin
					push = 1'b1;
					push_item.kind = KIND_DONE;
					push_item.fired_count = 5'(cnt_q);
					push_item.last = 1'b1;
					cmd.sweep = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q <= '0;
				cnt_q <= '0;
			end else if (state_q == ST_SCAN && step) begin
				idx_q <= idx_q + IDX_W'(1);
				if (hit) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the accepted item and the result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= in_item;
		end
		if (push) begin
			out_q <= push_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

	a_expired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind == KIND_EXPIRED |-> !out_item.last)
		else $error("expired result flagged as last");

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while another is in progress");

	a_sweep_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_item.kind == KIND_DONE |=> pending == '0)
		else $error("marked slots survive the end of a work pass");

	a_scan_no_host_item: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> in_q.op == OP_WORK)
		else $error("scan running for an item that is not a work pass");

endmodule
